### rtl/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

   localparam int SIZE_W  = 25;
   localparam int SLACK_W = 13;
   localparam int CSR_W   = 25;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_POOL_SIZE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_SLACK = 1'd1;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_ZERO_SIZE = 2'd1;
   localparam logic [1:0] ST_NO_FIT    = 2'd2;
   localparam logic [1:0] ST_NOT_ALLOC = 2'd3;

   // Request fields broadcast to every cell during a scan.
   typedef struct packed {
      logic               kind;
      logic [SIZE_W-1:0]  size;
      logic [SLACK_W-1:0] slack;
      logic               can_split;
   } scan_ctl_type;

   // What a cell reports when the scan token stops at it.
   typedef struct packed {
      logic              hit;
      logic              split;
      logic [SIZE_W-1:0] len;
   } cell_hit_type;

endpackage

### rtl/ffa_if.sv
// ----------------------------------------------------------------------------
// ffa_req_if / ffa_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface ffa_req_if #(parameter int OFFSET_BITS = 24);
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [24:0]            req_size;
   logic [12:0]            split_slack;
   logic [OFFSET_BITS-1:0] free_offset;

   modport source (output valid, kind, req_size, split_slack, free_offset, input ready);
   modport sink   (input valid, kind, req_size, split_slack, free_offset, output ready);
endinterface

interface ffa_rsp_if #(parameter int OFFSET_BITS = 24);
   logic                   valid;
   logic                   ready;
   logic [1:0]             status;
   logic [OFFSET_BITS-1:0] granted_offset;
   logic [24:0]            free_bytes;
   logic [24:0]            peak_used;

   modport source (output valid, status, granted_offset, free_bytes, peak_used, input ready);
   modport sink   (input valid, status, granted_offset, free_bytes, peak_used, output ready);
endinterface

### rtl/ffa_cell.sv
// ----------------------------------------------------------------------------
// ffa_cell
// One table entry of the allocator with its link of the scan token chain.
// ----------------------------------------------------------------------------
module ffa_cell #(
   parameter int OFFSET_BITS = 24,
   parameter bit FIRST       = 1'b0
) (
   input  logic                          clock,
   input  ffa_pkg::scan_ctl_type         ctl,
   input  logic [OFFSET_BITS-1:0]        off,
   input  logic                          tok_in,
   input  logic                          init,
   input  logic [ffa_pkg::SIZE_W-1:0]    init_len,
   input  logic                          app_we,
   input  logic [OFFSET_BITS-1:0]        app_start,
   input  logic [ffa_pkg::SIZE_W-1:0]    app_len,
   output logic                          tok_out,
   output ffa_pkg::cell_hit_type         hit,
   output logic [OFFSET_BITS-1:0]        hit_start
);
   import ffa_pkg::*;

   logic                   tok_ff;
   logic                   valid_ff;
   logic                   free_ff;
   logic [OFFSET_BITS-1:0] start_ff;
   logic [SIZE_W-1:0]      len_ff;
   logic                   match;
   logic                   split;
   logic [SIZE_W:0]        limit;

   assign limit = {1'b0, ctl.size} + {{(SIZE_W + 1 - SLACK_W){1'b0}}, ctl.slack};
   assign split = (ctl.kind == KIND_ALLOC) && ctl.can_split && ({1'b0, len_ff} > limit);

   always_comb begin
      if (ctl.kind == KIND_ALLOC) begin
         match = tok_ff && valid_ff && free_ff && (len_ff >= ctl.size);
      end else begin
         match = tok_ff && valid_ff && !free_ff && (start_ff == off);
      end
   end

   // The token moves on only past a cell that does not take the request.
   assign tok_out   = tok_ff && !match;
   assign hit.hit   = match;
   assign hit.split = split;
   assign hit.len   = len_ff;
   assign hit_start = start_ff;

   always_ff @(posedge clock) begin
      if (init) begin
         tok_ff   <= 1'b0;
         valid_ff <= FIRST;
         free_ff  <= FIRST;
         start_ff <= '0;
         len_ff   <= init_len;
      end else begin
         tok_ff <= tok_in;
         if (app_we) begin
            valid_ff <= 1'b1;
            free_ff  <= 1'b1;
            start_ff <= app_start;
            len_ff   <= app_len;
         end else if (match) begin
            free_ff <= (ctl.kind == KIND_FREE);
            if (split) begin
               len_ff <= ctl.size;
            end
         end
      end
   end

endmodule

### rtl/first_fit_block_allocator.sv
// A zero-size allocate goes straight to its result. Any other request scans the cells; a
// miss then goes to its result, a free updates the table first, and an allocate updates
// the table and then the peak usage. The scan token moves one cell a cycle. One request is
// in work at a time; a new request is accepted only in the idle state, which is reentered
// as the result is registered. Reset (synchronous) and any pool_size write rebuild the table.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator with block split over a chain of table cells.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
   parameter int MAX_BLOCKS  = 64,
   parameter int OFFSET_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   ffa_req_if.sink                         req_ch,
   ffa_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [ffa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ffa_pkg::CSR_W-1:0]       csr_data
);
   import ffa_pkg::*;

   localparam int CNT_W = $clog2(MAX_BLOCKS) + 1;
   localparam int CW    = (OFFSET_BITS + 1 > SIZE_W) ? OFFSET_BITS + 1 : SIZE_W;
   localparam logic [CW-1:0] POOL_MAX = CW'(1) << OFFSET_BITS;
   localparam logic [CW-1:0] POOL_DEF = CW'(1) << 24;
   localparam logic [CW-1:0] POOL_RST = (POOL_DEF > POOL_MAX) ? POOL_MAX : POOL_DEF;
   localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_UPD  = 3'd2;
   localparam logic [2:0] S_PEAK = 3'd3;
   localparam logic [2:0] S_RESP = 3'd4;

   logic [2:0]             state_ff, state_in;
   scan_ctl_type           ctl_ff;
   logic [OFFSET_BITS-1:0] off_ff;
   logic [SIZE_W-1:0]      pool_ff;
   logic [SLACK_W-1:0]     dslack_ff;
   logic [SIZE_W-1:0]      ftot_ff;
   logic [SIZE_W-1:0]      peak_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   hsplit_ff;
   logic [SIZE_W-1:0]      hlen_ff;
   logic [OFFSET_BITS-1:0] hstart_ff;
   logic [1:0]             st_ff;
   logic [OFFSET_BITS-1:0] goff_ff;
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   logic [OFFSET_BITS-1:0] rsp_off_ff;
   logic [SIZE_W-1:0]      rsp_free_ff;
   logic [SIZE_W-1:0]      rsp_peak_ff;

   logic                   accept;
   logic                   zero_alloc;
   logic                   pool_wr;
   logic                   init;
   logic [SIZE_W-1:0]      init_len;
   logic [SIZE_W-1:0]      pool_clamped;
   logic                   resp_load;

   logic [MAX_BLOCKS:0]    tok;
   cell_hit_type           cell_hit [MAX_BLOCKS];
   logic [OFFSET_BITS-1:0] cell_start [MAX_BLOCKS];
   logic [MAX_BLOCKS-1:0]  app_we;
   logic                   any_hit;
   logic                   any_split;
   logic [SIZE_W-1:0]      any_len;
   logic [OFFSET_BITS-1:0] any_start;
   logic                   do_split;
   logic [SIZE_W-1:0]      granted;
   logic [SIZE_W:0]        freed_sum;
   logic [SIZE_W-1:0]      used;

   assign accept     = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign zero_alloc = (req_ch.kind == KIND_ALLOC) && (req_ch.req_size == '0);
   assign pool_wr    = csr_we && (csr_index == CSR_POOL_SIZE);
   assign init       = reset || pool_wr;
   assign pool_clamped = (CW'(csr_data) > POOL_MAX) ? SIZE_W'(POOL_MAX) : csr_data;
   assign init_len   = reset ? SIZE_W'(POOL_RST) : pool_clamped;
   assign resp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ch.ready);
   assign tok[0]     = accept && !zero_alloc;

   // The hit cell is unique, so an OR across the row picks its data.
   always_comb begin
      any_hit   = 1'b0;
      any_split = 1'b0;
      any_len   = '0;
      any_start = '0;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
         any_hit   = any_hit | cell_hit[i].hit;
         any_split = any_split | (cell_hit[i].hit & cell_hit[i].split);
         any_len   = any_len | (cell_hit[i].hit ? cell_hit[i].len : '0);
         any_start = any_start | (cell_hit[i].hit ? cell_start[i] : '0);
      end
   end

   assign do_split  = (state_ff == S_UPD) && (ctl_ff.kind == KIND_ALLOC) && hsplit_ff;
   assign granted   = hsplit_ff ? ctl_ff.size : hlen_ff;
   assign freed_sum = {1'b0, ftot_ff} + {1'b0, hlen_ff};
   assign used      = (pool_ff >= ftot_ff) ? pool_ff - ftot_ff : '0;

   for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
      assign app_we[g] = do_split && (count_ff == CNT_W'(g));
      ffa_cell #(
         .OFFSET_BITS (OFFSET_BITS),
         .FIRST       (g == 0)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl_ff),
         .off       (off_ff),
         .tok_in    (tok[g]),
         .init      (init),
         .init_len  (init_len),
         .app_we    (app_we[g]),
         .app_start (hstart_ff + OFFSET_BITS'(ctl_ff.size)),
         .app_len   (hlen_ff - ctl_ff.size),
         .tok_out   (tok[g+1]),
         .hit       (cell_hit[g]),
         .hit_start (cell_start[g])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = zero_alloc ? S_RESP : S_SCAN;
            end
         end
         S_SCAN: begin
            if (any_hit) begin
               state_in = S_UPD;
            end else if (tok[MAX_BLOCKS]) begin
               state_in = S_RESP;
            end
         end
         S_UPD:  state_in = (ctl_ff.kind == KIND_ALLOC) ? S_PEAK : S_RESP;
         S_PEAK: state_in = S_RESP;
         S_RESP: begin
            if (resp_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pool_ff      <= SIZE_W'(POOL_RST);
         dslack_ff    <= SLACK_W'(64);
         ftot_ff      <= SIZE_W'(POOL_RST);
         peak_ff      <= '0;
         count_ff     <= CNT_W'(1);
      end else begin
         state_ff <= state_in;
         if (resp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (pool_wr) begin
            pool_ff  <= pool_clamped;
            ftot_ff  <= pool_clamped;
            peak_ff  <= '0;
            count_ff <= CNT_W'(1);
         end else if (state_ff == S_UPD) begin
            if (ctl_ff.kind == KIND_ALLOC) begin
               ftot_ff <= (ftot_ff >= granted) ? ftot_ff - granted : '0;
               if (hsplit_ff) begin
                  count_ff <= count_ff + CNT_W'(1);
               end
            end else begin
               ftot_ff <= freed_sum[SIZE_W] ? SIZE_MAX : freed_sum[SIZE_W-1:0];
            end
         end else if (state_ff == S_PEAK) begin
            if (used > peak_ff) begin
               peak_ff <= used;
            end
         end
         if (csr_we && (csr_index == CSR_DEFAULT_SLACK)) begin
            dslack_ff <= csr_data[SLACK_W-1:0];
         end
      end
   end

   // Request, hit and result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff.kind      <= req_ch.kind;
         ctl_ff.size      <= req_ch.req_size;
         ctl_ff.slack     <= (req_ch.split_slack == '0) ? dslack_ff : req_ch.split_slack;
         ctl_ff.can_split <= (count_ff < CNT_W'(MAX_BLOCKS));
         off_ff           <= req_ch.free_offset;
         st_ff            <= ST_ZERO_SIZE;
         goff_ff          <= '0;
      end
      if (state_ff == S_SCAN) begin
         hsplit_ff <= any_split;
         hlen_ff   <= any_len;
         hstart_ff <= any_start;
         if (any_hit) begin
            st_ff   <= ST_OK;
            goff_ff <= any_start;
         end else begin
            st_ff   <= (ctl_ff.kind == KIND_ALLOC) ? ST_NO_FIT : ST_NOT_ALLOC;
            goff_ff <= '0;
         end
      end
      if (resp_load) begin
         rsp_status_ff <= st_ff;
         rsp_off_ff    <= goff_ff;
         rsp_free_ff   <= ftot_ff;
         rsp_peak_ff   <= peak_ff;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.granted_offset = rsp_off_ff;
   assign rsp_ch.free_bytes     = rsp_free_ff;
   assign rsp_ch.peak_used      = rsp_peak_ff;

endmodule
